FILE: rtl/xsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr_pkg: shared definitions for the xorshift64* ranged generator
// Holds the generator constants, the request kind codes and the
// controller state encoding.
// ----------------------------------------------------------------------------
package xsr_pkg;

   // Reset value of the generator state and of the seed register. A zero
   // seed is replaced with it on reseed.
   localparam logic [63:0] GOLDEN_SEED = 64'h9E37_79B9_7F4A_7C15;

   // Output scrambling multiplier and its multiples for radix-4 digits.
   localparam logic [63:0] STAR_MULT   = 64'h2545_F491_4F6C_DD1D;
   localparam logic [63:0] STAR_MULT2  = {STAR_MULT[62:0], 1'b0};
   localparam logic [63:0] STAR_MULT3  = STAR_MULT + STAR_MULT2;

   // Xorshift step amounts.
   localparam int unsigned SHIFT_A = 13;
   localparam int unsigned SHIFT_B = 7;
   localparam int unsigned SHIFT_C = 17;

   // Width of the words handed out and number of two-bit multiply digits.
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned STATE_W    = 64;
   localparam int unsigned MUL_STEPS  = STATE_W / 2;
   localparam int unsigned DIV_STEPS  = WORD_W;
   localparam int unsigned COUNT_W    = $clog2(MUL_STEPS);

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_RAW    = 2'd0,
      KIND_RANGED = 2'd1,
      KIND_COIN   = 2'd2,
      KIND_RESEED = 2'd3
   } kind_type;

   // Controller states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_STEP = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   // One xorshift64 step on the generator state.
   function automatic logic [63:0] xorshift_step(input logic [63:0] x);
      logic [63:0] t;
      t = x ^ (x << SHIFT_A);
      t = t ^ (t >> SHIFT_B);
      t = t ^ (t << SHIFT_C);
      return t;
   endfunction

endpackage

FILE: rtl/xorshift_star_ranged_rng.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift_star_ranged_rng: xorshift64* generator with ranged output
// Steps a 64-bit xorshift state, scrambles it with a digit-serial constant
// multiply and reduces the word into a signed range with a bit-serial
// remainder unit.
// ----------------------------------------------------------------------------
//
// Usage:
//   A request word (req_*) carries a kind and two bounds; each request gives
//   exactly one response word (rsp_*). Kind 0 returns a raw 32-bit word,
//   kind 1 a signed value within the inclusive bounds (in either order),
//   kind 2 a coin bit, and kind 3 reloads the generator from the seed
//   register (csr_*) and returns all zeros. The seed register may be written
//   whenever no request is in progress; csr_ready is always high.
//
//   Kinds 0 and 2, and kind 1 with the full 32-bit range, go through the
//   step, multiply and finish states; other kind 1 requests also go through
//   the remainder state, and a reseed goes straight to finish. The radix-4
//   multiplier is followed by the restoring remainder unit, one bit per
//   cycle. One request is worked on at a time; a new one is taken in the
//   cycle after the result moves to the output register, even while a
//   finished response still waits there.
//   If the receiver stalls, the finished result holds in the controller
//   until the output register frees up.
//   Reset loads the golden-ratio constant into state and seed register.
//
module xorshift_star_ranged_rng (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   // Response channel.
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_raw_word,
   output logic signed [31:0] rsp_ranged_value,
   output logic               rsp_coin_bit,
   // Seed register write channel.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [63:0]        csr_seed_value
);
   import xsr_pkg::*;

   // Control registers.
   state_type            fsm_ff, fsm_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [STATE_W-1:0]   gen_ff, gen_in;
   logic [STATE_W-1:0]   seed_ff, seed_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   kind_type             kind_ff, kind_in;
   logic [WORD_W-1:0]    lo_ff, lo_in;
   logic [WORD_W-1:0]    hi_ff, hi_in;
   logic [WORD_W-1:0]    span_ff, span_in;
   logic [STATE_W-1:0]   mul_x_ff, mul_x_in;
   logic [STATE_W-1:0]   acc_ff, acc_in;
   logic [WORD_W-1:0]    div_q_ff, div_q_in;
   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WORD_W-1:0]    out_raw_ff, out_raw_in;
   logic [WORD_W-1:0]    out_ranged_ff, out_ranged_in;
   logic                 out_coin_ff, out_coin_in;

   // Combinational helpers.
   logic                 req_fire;
   logic                 out_load;
   logic                 count_last;
   logic [STATE_W-1:0]   mul_digit;
   logic [WORD_W:0]      rem_shift;
   logic [WORD_W:0]      rem_trial;
   logic [WORD_W-1:0]    raw_word;

   assign req_ready  = (fsm_ff == ST_IDLE);
   assign req_fire   = req_valid & req_ready;
   assign csr_ready  = 1'b1;
   assign count_last = (count_ff == COUNT_W'(MUL_STEPS - 1));
   assign out_load   = (fsm_ff == ST_FIN) & (~rsp_valid_ff | rsp_ready);
   assign raw_word   = acc_ff[STATE_W-1 -: WORD_W];

   // Multiplier digit: the top two bits of the state pick a multiple.
   always_comb begin
      case (mul_x_ff[STATE_W-1 -: 2])
         2'd0:    mul_digit = '0;
         2'd1:    mul_digit = STAR_MULT;
         2'd2:    mul_digit = STAR_MULT2;
         2'd3:    mul_digit = STAR_MULT3;
         default: mul_digit = '0;
      endcase
   end

   // Remainder trial subtraction: bring in the next dividend bit.
   assign rem_shift = {rem_ff, div_q_ff[WORD_W-1]};
   assign rem_trial = rem_shift - {1'b0, span_ff};

   // Next-state logic for the controller and datapath.
   always_comb begin
      fsm_in        = fsm_ff;
      count_in      = count_ff;
      gen_in        = gen_ff;
      seed_in       = seed_ff;
      kind_in       = kind_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      span_in       = span_ff;
      mul_x_in      = mul_x_ff;
      acc_in        = acc_ff;
      div_q_in      = div_q_ff;
      rem_in        = rem_ff;
      out_raw_in    = out_raw_ff;
      out_ranged_in = out_ranged_ff;
      out_coin_in   = out_coin_ff;

      // Seed register write.
      if (csr_valid & csr_ready) begin
         seed_in = csr_seed_value;
      end

      case (fsm_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in = kind_type'(req_kind);
               // Order the bounds so that lo is the smaller one.
               if (req_range_low > req_range_high) begin
                  lo_in = req_range_high;
                  hi_in = req_range_low;
               end else begin
                  lo_in = req_range_low;
                  hi_in = req_range_high;
               end
               if (kind_type'(req_kind) == KIND_RESEED) begin
                  gen_in = (seed_ff != '0) ? seed_ff : GOLDEN_SEED;
                  fsm_in = ST_FIN;
               end else begin
                  fsm_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            // Advance the state and set up the multiply.
            gen_in   = xorshift_step(gen_ff);
            mul_x_in = xorshift_step(gen_ff);
            acc_in   = '0;
            count_in = '0;
            span_in  = hi_ff - lo_ff + WORD_W'(1);
            fsm_in   = ST_MUL;
         end
         ST_MUL: begin
            // Horner step, most significant digit first, modulo 2^64.
            acc_in   = {acc_ff[STATE_W-3:0], 2'b00} + mul_digit;
            mul_x_in = {mul_x_ff[STATE_W-3:0], 2'b00};
            count_in = count_ff + COUNT_W'(1);
            if (count_last) begin
               count_in = '0;
               div_q_in = acc_in[STATE_W-1 -: WORD_W];
               rem_in   = '0;
               if ((kind_ff == KIND_RANGED) && (span_ff != '0)) begin
                  fsm_in = ST_DIV;
               end else begin
                  fsm_in = ST_FIN;
               end
            end
         end
         ST_DIV: begin
            // Restoring remainder, one dividend bit per cycle.
            div_q_in = {div_q_ff[WORD_W-2:0], 1'b0};
            if (!rem_trial[WORD_W]) begin
               rem_in = rem_trial[WORD_W-1:0];
            end else begin
               rem_in = rem_shift[WORD_W-1:0];
            end
            count_in = count_ff + COUNT_W'(1);
            if (count_ff == COUNT_W'(DIV_STEPS - 1)) begin
               count_in = '0;
               fsm_in   = ST_FIN;
            end
         end
         ST_FIN: begin
            // Hand the result to the output register once it is free.
            if (out_load) begin
               out_raw_in    = (kind_ff == KIND_RESEED) ? '0 : raw_word;
               out_ranged_in = '0;
               out_coin_in   = 1'b0;
               if (kind_ff == KIND_RANGED) begin
                  out_ranged_in = (span_ff == '0) ? raw_word : (lo_ff + rem_ff);
               end
               if (kind_ff == KIND_COIN) begin
                  out_coin_in = raw_word[0];
               end
               fsm_in = ST_IDLE;
            end
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: set on load, cleared when the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         count_ff     <= '0;
         gen_ff       <= GOLDEN_SEED;
         seed_ff      <= GOLDEN_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         count_ff     <= count_in;
         gen_ff       <= gen_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      span_ff       <= span_in;
      mul_x_ff      <= mul_x_in;
      acc_ff        <= acc_in;
      div_q_ff      <= div_q_in;
      rem_ff        <= rem_in;
      out_raw_ff    <= out_raw_in;
      out_ranged_ff <= out_ranged_in;
      out_coin_ff   <= out_coin_in;
   end

   // Response ports.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_raw_word     = out_raw_ff;
   assign rsp_ranged_value = out_ranged_ff;
   assign rsp_coin_bit     = out_coin_ff;

endmodule
